>>> design/otdpt_pkg.sv
package otdpt_pkg;

   // First odd divisor tried, and the step between trial divisors
   localparam int unsigned FIRST_DIVISOR = 3;
   localparam int unsigned DIVISOR_STEP  = 2;

   // Remainder unit -> sequencer
   typedef struct packed {
      logic done;     // one-cycle pulse: remainder is final
      logic is_zero;  // remainder equals zero
   } rem_status_type;

   // Sequencer -> top level
   typedef struct packed {
      logic idle;     // ready for a new candidate
      logic done;     // verdict is held and waits for the output register
      logic found;    // an odd factor was found
   } ctrl_status_type;

endpackage

>>> design/odd_trial_division_prime_test_unit.sv
// Odd trial-division prime test.
//
// Input channel (req_*): one transaction carries one candidate in the low
// VALUE_WIDTH bits of req_tdata. Result channel (rsp_*): one transaction per
// candidate with has_odd_factor in bit 0 and is_prime in bit 1.
// The block tries odd divisors 3, 5, 7, ... while d*d <= candidate and stops
// at the first one that divides it. Even candidates are not tested for 2.
// Each trial divisor takes one bound check, one bit per cycle through the
// shared restoring remainder unit, and a final step to read its verdict. A
// prime near 2^31 needs about 23170 divisors; a candidate below 9 goes from
// the bound check straight to its verdict.
// req_tready is high only while the sequencer is idle, so one candidate is in
// work at a time. The verdict moves into a one-entry output register; the
// next candidate may be taken while that result waits for rsp_tready. If the
// receiver stalls longer than a full search, the sequencer holds its verdict
// until the output register frees up.
// Reset (synchronous, active high) drops any search in progress and any
// pending result; nothing carries over between candidates.
module odd_trial_division_prime_test_unit #(
   parameter int VALUE_WIDTH = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     req_tdata,   // [VALUE_WIDTH-1:0] candidate
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [7:0]                           rsp_tdata    // [0] has_odd_factor, [1] is_prime
);

   // d never exceeds about 2^(VALUE_WIDTH/2) + 2
   localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;

   otdpt_pkg::ctrl_status_type ctrl_status;
   otdpt_pkg::rem_status_type  rem_status;

   logic                   start;
   logic                   take;
   logic                   rem_start;
   logic [VALUE_WIDTH-1:0] held_candidate;
   logic [DIV_WIDTH-1:0]   divisor;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_found_in;

   // Accept a transaction only while the sequencer is idle
   assign req_tready = ctrl_status.idle;
   assign start      = req_tvalid & ctrl_status.idle;

   // Move the verdict out when the output register is empty or draining
   assign take = ctrl_status.done & (~rsp_valid_ff | rsp_tready);

   otdpt_ctrl #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH   (DIV_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .candidate      (req_tdata[VALUE_WIDTH-1:0]),
      .take           (take),
      .rem_status     (rem_status),
      .rem_start      (rem_start),
      .held_candidate (held_candidate),
      .divisor        (divisor),
      .status         (ctrl_status)
   );

   otdpt_rem #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH   (DIV_WIDTH)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (held_candidate),
      .divisor  (divisor),
      .status   (rem_status)
   );

   // Output register: load on take, drop on a completed transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = ctrl_status.found;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, ~rsp_found_ff, rsp_found_ff};

endmodule

>>> design/otdpt_rem.sv
module otdpt_rem #(
   parameter int VALUE_WIDTH = 31,
   parameter int DIV_WIDTH   = 17
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [VALUE_WIDTH-1:0]     dividend,
   input  logic [DIV_WIDTH-1:0]       divisor,
   output otdpt_pkg::rem_status_type  status
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic [CNT_W-1:0]       cnt_ff,   cnt_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0]   rem_ff,   rem_in;

   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     diff;
   logic [DIV_WIDTH-1:0]   rem_next;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff     = trial - {1'b0, divisor};
   assign rem_next = diff[DIV_WIDTH] ? trial[DIV_WIDTH-1:0] : diff[DIV_WIDTH-1:0];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = rem_next;
         shift_in = {shift_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign status.done    = done_ff;
   assign status.is_zero = (rem_ff == '0);

endmodule

>>> design/otdpt_ctrl.sv
module otdpt_ctrl #(
   parameter int VALUE_WIDTH = 31,
   parameter int DIV_WIDTH   = 17
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [VALUE_WIDTH-1:0]      candidate,
   input  logic                        take,
   input  otdpt_pkg::rem_status_type   rem_status,
   output logic                        rem_start,
   output logic [VALUE_WIDTH-1:0]      held_candidate,
   output logic [DIV_WIDTH-1:0]        divisor,
   output otdpt_pkg::ctrl_status_type  status
);

   localparam int SQ_W = 2 * DIV_WIDTH;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] cand_ff,  cand_in;
   logic [DIV_WIDTH-1:0]   d_ff,     d_in;
   logic [SQ_W-1:0]        sq_ff,    sq_in;
   logic                   found_ff, found_in;

   always_comb begin
      state_in  = state_ff;
      cand_in   = cand_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      found_in  = found_ff;
      rem_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cand_in  = candidate;
               d_in     = DIV_WIDTH'(otdpt_pkg::FIRST_DIVISOR);
               sq_in    = SQ_W'(otdpt_pkg::FIRST_DIVISOR * otdpt_pkg::FIRST_DIVISOR);
               found_in = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // stop once d*d passes the candidate
            if (sq_ff > SQ_W'(cand_ff)) begin
               state_in = ST_DONE;
            end else begin
               rem_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_status.done) begin
               if (rem_status.is_zero) begin
                  found_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  // (d+s)^2 = d^2 + 2*s*d + s^2
                  d_in     = d_ff + DIV_WIDTH'(otdpt_pkg::DIVISOR_STEP);
                  sq_in    = sq_ff
                           + SQ_W'(d_ff) * SQ_W'(2 * otdpt_pkg::DIVISOR_STEP)
                           + SQ_W'(otdpt_pkg::DIVISOR_STEP * otdpt_pkg::DIVISOR_STEP);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff  <= cand_in;
      d_ff     <= d_in;
      sq_ff    <= sq_in;
      found_ff <= found_in;
   end

   assign held_candidate = cand_ff;
   assign divisor        = d_ff;
   assign status.idle    = (state_ff == ST_IDLE);
   assign status.done    = (state_ff == ST_DONE);
   assign status.found   = found_ff;

endmodule

>>> design/otdpt_checker.sv
module otdpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // The prime flag is always the inverse of the factor flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] != rsp_tdata[1]))
      else $error("is_prime is not the inverse of has_odd_factor");

   // Reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   // One candidate at a time: busy right after taking a transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still ready right after a transaction");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind odd_trial_division_prime_test_unit otdpt_checker u_otdpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/odd_trial_division_prime_test_unit_test.sv
`timescale 1ns / 1ps

module odd_trial_division_prime_test_unit_test;

   localparam int VALUE_WIDTH = 31;
   localparam int DATA_BYTES = (VALUE_WIDTH + 7) / 8;
   // A prime near 2^31 tries about 23170 divisors with no transaction on either side
   localparam int WATCHDOG_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 25;
   localparam int PHASE_COUNT = 4;
   localparam int DIRECTED_COUNT = 22;

   typedef logic [VALUE_WIDTH-1:0] candidate_type;

   typedef struct packed {
      logic has_odd_factor;
      logic is_prime;
   } verdict_type;

   // One row of directed stimulus; typed rows carry their verdict, the rest go
   // through the predictor.
   typedef struct packed {
      candidate_type candidate;
      logic          typed;
      logic          has_odd_factor;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // candidates below 9: no divisor in range, so all report prime
      '{31'd0,           1'b1, 1'b0},
      '{31'd1,           1'b1, 1'b0},
      '{31'd2,           1'b1, 1'b0},
      '{31'd3,           1'b1, 1'b0},
      '{31'd4,           1'b1, 1'b0},
      '{31'd6,           1'b1, 1'b0},
      '{31'd7,           1'b1, 1'b0},
      '{31'd8,           1'b1, 1'b0},
      // bound reached exactly: d*d == candidate
      '{31'd9,           1'b1, 1'b1},
      '{31'd25,          1'b1, 1'b1},
      '{31'd49,          1'b1, 1'b1},
      // even candidate caught through an odd factor
      '{31'd12,          1'b1, 1'b1},
      '{31'd10,          1'b0, 1'b0},
      '{31'd15,          1'b0, 1'b0},
      '{31'd97,          1'b0, 1'b0},
      '{31'd121,         1'b0, 1'b0},
      '{31'd1021,        1'b0, 1'b0},
      '{31'd4095,        1'b0, 1'b0},
      // wide patterns: all divisible by 3 or 5
      '{31'h5555_5555,   1'b1, 1'b1},
      '{31'h2AAA_AAAA,   1'b1, 1'b1},
      '{31'h7FFF_FFFE,   1'b1, 1'b1},
      // largest value is a Mersenne prime: the longest search there is
      '{31'h7FFF_FFFF,   1'b1, 1'b0}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [DATA_BYTES*8-1:0]   req_tdata;   // [30:0] candidate
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;   // [0] has_odd_factor, [1] is_prime

   verdict_type expected_verdicts [$];
   int          error_count = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          quiet_cycles = 0;

   odd_trial_division_prime_test_unit #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Search odd divisors 3, 5, 7, ... while d*d stays within the candidate.
   function automatic verdict_type predict_verdict(input candidate_type candidate);
      logic [63:0] divisor;
      logic [63:0] value;
      logic        found;
      verdict_type verdict;
      value = {{(64-VALUE_WIDTH){1'b0}}, candidate};
      found = 1'b0;
      for (divisor = otdpt_pkg::FIRST_DIVISOR; !found && divisor * divisor <= value;
           divisor += otdpt_pkg::DIVISOR_STEP) begin
         if (value % divisor == 0) found = 1'b1;
      end
      verdict.has_odd_factor = found;
      verdict.is_prime = ~found;
      return verdict;
   endfunction

   // Mostly odd candidates that reach deep into the search; some noise on top.
   function automatic candidate_type draw_candidate();
      int unsigned   pick;
      int unsigned   factor;
      candidate_type wide;
      pick = $urandom_range(99);
      if (pick < 40) begin
         return candidate_type'(2 * $urandom_range(1, 2047) + 1);
      end else if (pick < 60) begin
         return candidate_type'((2 * $urandom_range(1, 31) + 1)
                                * (2 * $urandom_range(1, 31) + 1));
      end else if (pick < 78) begin
         // full width, but with a small odd factor so the search ends early
         case ($urandom_range(4))
            0: factor = 3;
            1: factor = 5;
            2: factor = 7;
            3: factor = 9;
            default: factor = 15;
         endcase
         wide = candidate_type'($urandom());
         return wide - candidate_type'(wide % factor);
      end else if (pick < 83) begin
         return candidate_type'(2 * $urandom_range(0, 524287) + 1);
      end else if (pick < 91) begin
         return candidate_type'($urandom_range(0, 40));
      end else begin
         return candidate_type'(2 * $urandom_range(0, 2047));
      end
   endfunction

   // Offer one candidate, idling first as the phase asks, and hold it until
   // the transaction completes.
   task automatic send_candidate(input candidate_type candidate, input verdict_type verdict);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(DATA_BYTES*8-VALUE_WIDTH){1'b0}}, candidate};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_verdicts.push_back(verdict);
   endtask

   task automatic wait_drained();
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // Stall the receiver at random; the rate follows the phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare each result transaction with the oldest verdict waiting.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: result with none expected: tdata %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[0] !== want.has_odd_factor) begin
               $display("%0t: has_odd_factor expected %b actual %b",
                        $time, want.has_odd_factor, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want.is_prime) begin
               $display("%0t: is_prime expected %b actual %b",
                        $time, want.is_prime, rsp_tdata[1]);
               error_count++;
            end
         end
      end
   end

   // Drop the run if no transaction moves on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      verdict_type   verdict;
      candidate_type candidate;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, no idling on either side.
      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].typed) begin
            verdict.has_odd_factor = DIRECTED_ROWS[i].has_odd_factor;
            verdict.is_prime = ~DIRECTED_ROWS[i].has_odd_factor;
         end else begin
            verdict = predict_verdict(DIRECTED_ROWS[i].candidate);
         end
         send_candidate(DIRECTED_ROWS[i].candidate, verdict);
      end

      // Random phases; hold the sender until the block has drained at each start.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         case (phase)
            0: begin req_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin req_idle_pct <= 69; rsp_stall_pct <= 0;  end
            2: begin req_idle_pct <= 0;  rsp_stall_pct <= 69; end
            default: begin req_idle_pct <= 14; rsp_stall_pct <= 14; end
         endcase
         @(posedge clock);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            candidate = draw_candidate();
            send_candidate(candidate, predict_verdict(candidate));
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
